// ----- hw/rtl/pfa_pkg.sv -----
// pfa_pkg: shared types and constants for the polygon fan area block.
// Used by pfa_front, pfa_back and polygon_fan_area; no dependencies.
package pfa_pkg;

    localparam int CoordWidth = 16;
    localparam int AreaWidth  = 38;
    localparam int CountWidth = 4;
    localparam int DiffWidth  = 17;
    localparam int CrossWidth = 35;
    localparam int MagWidth   = 34;
    localparam int NormWidth  = 70;
    localparam int RootWidth  = 36;
    localparam int StepWidth  = 6;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_LONG  = 2'd2;

    // One job handed from the front to the back
    typedef struct packed {
        logic signed [CoordWidth-1:0] v0_x;
        logic signed [CoordWidth-1:0] v0_y;
        logic signed [CoordWidth-1:0] v0_z;
        logic signed [CoordWidth-1:0] vi_x;
        logic signed [CoordWidth-1:0] vi_y;
        logic signed [CoordWidth-1:0] vi_z;
        logic signed [CoordWidth-1:0] vj_x;
        logic signed [CoordWidth-1:0] vj_y;
        logic signed [CoordWidth-1:0] vj_z;
        logic                         has_tri;
        logic                         emit;
        logic [CountWidth-1:0]        tri_count;
        logic [1:0]                   status;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CROSS,
        ST_SQUARE,
        ST_ROOT,
        ST_ACCUM,
        ST_OUT
    } back_state_t;

endpackage

// ----- hw/rtl/pfa_front.sv -----
// pfa_front: accepts vertices, tracks face state, classifies each into a job.
// Depends on pfa_pkg.
module pfa_front #(
    parameter int MAX_SIDES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [15:0]         x_in,
    input  logic [15:0]         y_in,
    input  logic [15:0]         z_in,
    input  logic                last_in,
    output logic                job_valid,
    input  logic                job_ready,
    output pfa_pkg::job_t       job_out
);
    localparam int CntW = $clog2(MAX_SIDES + 2);
    localparam int CapI = (MAX_SIDES - 2 > 15) ? 15 : MAX_SIDES - 2;
    localparam logic [CntW-1:0] CntMax = CntW'(MAX_SIDES + 1);

    logic [CntW-1:0]  count_reg, count_next, count_inc;
    logic [47:0]      first_reg, prev_reg;
    pfa_pkg::job_t    job_reg, job_next;
    logic             jv_reg, jv_next;
    logic             take;

    assign in_ready  = !jv_reg || job_ready;
    assign take      = in_valid && in_ready;
    assign job_valid = jv_reg;
    assign job_out   = job_reg;
    assign count_inc = (count_reg < CntMax) ? count_reg + 1'b1 : count_reg;

    // Build the job for the incoming vertex
    always_comb begin
        job_next      = job_reg;
        job_next.vj_x = x_in;
        job_next.vj_y = y_in;
        job_next.vj_z = z_in;
        job_next.v0_x = (count_reg == '0) ? x_in : first_reg[47:32];
        job_next.v0_y = (count_reg == '0) ? y_in : first_reg[31:16];
        job_next.v0_z = (count_reg == '0) ? z_in : first_reg[15:0];
        job_next.vi_x = prev_reg[47:32];
        job_next.vi_y = prev_reg[31:16];
        job_next.vi_z = prev_reg[15:0];
        job_next.has_tri = (count_reg >= CntW'(2));
        job_next.emit    = last_in;
        if (count_inc < CntW'(3)) begin
            job_next.status    = pfa_pkg::STATUS_SHORT;
            job_next.tri_count = '0;
        end else begin
            job_next.status = (count_inc > CntW'(MAX_SIDES)) ? pfa_pkg::STATUS_LONG
                                                             : pfa_pkg::STATUS_OK;
            job_next.tri_count = (count_inc - CntW'(2) > CntW'(CapI))
                ? pfa_pkg::CountWidth'(CapI)
                : pfa_pkg::CountWidth'(count_inc - CntW'(2));
        end
        jv_next    = take ? 1'b1 : (job_ready ? 1'b0 : jv_reg);
        count_next = take ? (last_in ? '0 : count_inc) : count_reg;
    end

    // Hold face state and the job register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            jv_reg    <= 1'b0;
        end else begin
            count_reg <= count_next;
            jv_reg    <= jv_next;
        end
        if (take) begin
            job_reg  <= job_next;
            prev_reg <= {x_in, y_in, z_in};
            if (count_reg == '0) first_reg <= {x_in, y_in, z_in};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        take && last_in |=> count_reg == '0)
        else $error("count not cleared after last vertex");
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntMax)
        else $error("vertex count over its limit");
    assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> jv_reg)
        else $error("accepted vertex produced no job");
endmodule

// ----- hw/rtl/pfa_back.sv -----
// pfa_back: cross product, squared norm, bit-serial root and area sum.
// Depends on pfa_pkg.
module pfa_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         job_valid,
    output logic                         job_ready,
    input  pfa_pkg::job_t                job_in,
    output logic                         res_valid,
    input  logic                         res_ready,
    output logic [pfa_pkg::AreaWidth-1:0]  res_area,
    output logic [pfa_pkg::CountWidth-1:0] res_count,
    output logic [1:0]                   res_status
);
    localparam logic [pfa_pkg::AreaWidth-1:0] AreaMax = '1;

    pfa_pkg::back_state_t state_reg, state_next;
    pfa_pkg::job_t        job_reg;
    logic signed [pfa_pkg::DiffWidth-1:0]  ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [pfa_pkg::CrossWidth-1:0] c_reg [3];
    logic [1:0]                            idx_reg, idx_next;
    logic [pfa_pkg::NormWidth-1:0]         norm_reg, norm_next;
    logic [pfa_pkg::NormWidth-1:0]         rem_reg, rem_next;
    logic [pfa_pkg::RootWidth-1:0]         root_reg, root_next;
    logic [pfa_pkg::StepWidth-1:0]         step_reg, step_next;
    logic [pfa_pkg::AreaWidth-1:0]         sum_reg, sum_next;
    logic                                  out_v_reg, out_v_next;
    logic [pfa_pkg::AreaWidth-1:0]         oarea_reg;
    logic [pfa_pkg::CountWidth-1:0]        ocnt_reg;
    logic [1:0]                            ostat_reg;
    logic [pfa_pkg::MagWidth-1:0]          mag_c;
    logic signed [pfa_pkg::CrossWidth-1:0] csel;
    logic [pfa_pkg::NormWidth+1:0]         trial, rem_sh;
    logic [pfa_pkg::AreaWidth:0]           sum_add;
    logic                                  load, out_free;

    assign out_free  = !out_v_reg || res_ready;
    assign job_ready = (state_reg == pfa_pkg::ST_IDLE);
    assign load      = job_valid && job_ready;
    assign res_valid = out_v_reg;
    assign res_area  = oarea_reg;
    assign res_count = ocnt_reg;
    assign res_status = ostat_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pfa_pkg::ST_IDLE:
                if (job_valid) begin
                    state_next = job_in.has_tri ? pfa_pkg::ST_CROSS : pfa_pkg::ST_ACCUM;
                end
            pfa_pkg::ST_CROSS:  state_next = pfa_pkg::ST_SQUARE;
            pfa_pkg::ST_SQUARE: if (idx_reg == 2'd2) state_next = pfa_pkg::ST_ROOT;
            pfa_pkg::ST_ROOT:   if (step_reg == '0) state_next = pfa_pkg::ST_ACCUM;
            pfa_pkg::ST_ACCUM:
                state_next = job_reg.emit ? pfa_pkg::ST_OUT : pfa_pkg::ST_IDLE;
            pfa_pkg::ST_OUT:    if (out_free) state_next = pfa_pkg::ST_IDLE;
            default:            state_next = pfa_pkg::ST_IDLE;
        endcase
    end

    // Datapath: one square per cycle, one root bit per cycle (restoring)
    always_comb begin
        csel = c_reg[idx_reg];
        mag_c = csel[pfa_pkg::CrossWidth-1] ? pfa_pkg::MagWidth'(-csel)
                                            : pfa_pkg::MagWidth'(csel);
        idx_next  = idx_reg;
        norm_next = norm_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        sum_next  = sum_reg;
        out_v_next = out_v_reg && !res_ready;
        rem_sh = {rem_reg, norm_reg[pfa_pkg::NormWidth-1 -: 2]};
        trial  = {{(pfa_pkg::NormWidth-pfa_pkg::RootWidth){1'b0}}, root_reg, 2'b01};
        sum_add = {1'b0, sum_reg} + {{(pfa_pkg::AreaWidth+1-pfa_pkg::RootWidth){1'b0}}, root_reg};
        case (state_reg)
            pfa_pkg::ST_CROSS: begin
                idx_next  = '0;
                norm_next = '0;
            end
            pfa_pkg::ST_SQUARE: begin
                norm_next = norm_reg + pfa_pkg::NormWidth'(mag_c * mag_c);
                idx_next  = idx_reg + 2'd1;
                rem_next  = '0;
                root_next = '0;
                // one step per pair of norm bits
                step_next = pfa_pkg::StepWidth'(pfa_pkg::NormWidth / 2 - 1);
            end
            pfa_pkg::ST_ROOT: begin
                if (rem_sh >= trial) begin
                    rem_next  = pfa_pkg::NormWidth'(rem_sh - trial);
                    root_next = {root_reg[pfa_pkg::RootWidth-2:0], 1'b1};
                end else begin
                    rem_next  = pfa_pkg::NormWidth'(rem_sh);
                    root_next = {root_reg[pfa_pkg::RootWidth-2:0], 1'b0};
                end
                norm_next = {norm_reg[pfa_pkg::NormWidth-3:0], 2'b00};
                step_next = step_reg - 1'b1;
            end
            pfa_pkg::ST_ACCUM: begin
                if (job_reg.has_tri) begin
                    sum_next = sum_add[pfa_pkg::AreaWidth] ? AreaMax
                                                           : sum_add[pfa_pkg::AreaWidth-1:0];
                end
            end
            pfa_pkg::ST_OUT: begin
                if (out_free) begin
                    out_v_next = 1'b1;
                    sum_next   = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfa_pkg::ST_IDLE;
            sum_reg   <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            out_v_reg <= out_v_next;
        end
        idx_reg  <= idx_next;
        norm_reg <= norm_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        step_reg <= step_next;
        if (load) begin
            job_reg <= job_in;
            ax_reg <= pfa_pkg::DiffWidth'(job_in.vj_x) - pfa_pkg::DiffWidth'(job_in.vi_x);
            ay_reg <= pfa_pkg::DiffWidth'(job_in.vj_y) - pfa_pkg::DiffWidth'(job_in.vi_y);
            az_reg <= pfa_pkg::DiffWidth'(job_in.vj_z) - pfa_pkg::DiffWidth'(job_in.vi_z);
            bx_reg <= pfa_pkg::DiffWidth'(job_in.v0_x) - pfa_pkg::DiffWidth'(job_in.vi_x);
            by_reg <= pfa_pkg::DiffWidth'(job_in.v0_y) - pfa_pkg::DiffWidth'(job_in.vi_y);
            bz_reg <= pfa_pkg::DiffWidth'(job_in.v0_z) - pfa_pkg::DiffWidth'(job_in.vi_z);
        end
        if (state_reg == pfa_pkg::ST_CROSS) begin
            c_reg[0] <= pfa_pkg::CrossWidth'(ay_reg * bz_reg) - pfa_pkg::CrossWidth'(az_reg * by_reg);
            c_reg[1] <= pfa_pkg::CrossWidth'(az_reg * bx_reg) - pfa_pkg::CrossWidth'(ax_reg * bz_reg);
            c_reg[2] <= pfa_pkg::CrossWidth'(ax_reg * by_reg) - pfa_pkg::CrossWidth'(ay_reg * bx_reg);
        end
        if (state_reg == pfa_pkg::ST_OUT && out_free) begin
            oarea_reg <= (job_reg.status == pfa_pkg::STATUS_SHORT) ? '0 : sum_reg;
            ocnt_reg  <= job_reg.tri_count;
            ostat_reg <= job_reg.status;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg && !res_ready |=> out_v_reg)
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pfa_pkg::ST_ROOT |-> step_reg < pfa_pkg::StepWidth'(pfa_pkg::RootWidth))
        else $error("root step out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> state_reg == pfa_pkg::ST_CROSS || state_reg == pfa_pkg::ST_ACCUM)
        else $error("job load did not start work");
endmodule

// ----- hw/rtl/polygon_fan_area.sv -----
// polygon_fan_area: top level joining the vertex front and the area back.
// Depends on pfa_pkg, pfa_front and pfa_back.
//
// Streams one vertex per beat and returns one beat per face on the last vertex:
// area in units of 2^-1 (twice the fan area), the fan triangle count and a status. Each vertex that
// closes a triangle goes through job load, cross product, three squaring steps,
// a bit-serial square root and accumulate in the back end; the first two
// vertices of a face skip from job load to accumulate. The last vertex of a
// face then hands its beat to the output register, waiting while a held beat
// sees m_tready low. The root iteration sets the rate. A one-job register
// between front and back lets the next vertex be taken while one works.
module polygon_fan_area #(
    parameter int MAX_SIDES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // x_coord, y_coord, z_coord
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // face_area, triangle_count, status, zero pad
);
    logic          job_valid, job_ready;
    pfa_pkg::job_t job;
    logic [pfa_pkg::AreaWidth-1:0]  area;
    logic [pfa_pkg::CountWidth-1:0] cnt;
    logic [1:0]                     stat;

    pfa_front #(.MAX_SIDES(MAX_SIDES)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .x_in(s_tdata[15:0]), .y_in(s_tdata[31:16]), .z_in(s_tdata[47:32]),
        .last_in(s_tlast),
        .job_valid(job_valid), .job_ready(job_ready), .job_out(job)
    );

    pfa_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(job_valid), .job_ready(job_ready), .job_in(job),
        .res_valid(m_tvalid), .res_ready(m_tready),
        .res_area(area), .res_count(cnt), .res_status(stat)
    );

    assign m_tdata = {4'b0000, stat, cnt, area};
endmodule
